/* src/salcp_pkg.sv */
package salcp_pkg;

  localparam int MAX_LEN   = 1024;
  localparam int ADDR_W    = $clog2(MAX_LEN);
  localparam int LEN_W     = ADDR_W + 1;
  localparam int CNT_DEPTH = MAX_LEN + 1;
  localparam int CNT_AW    = $clog2(CNT_DEPTH);

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_BUILT = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  // Requests from the stream side into the build engine.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_idx;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              start;
    logic [LEN_W-1:0]  n;
  } salcp_req_t;

  // Engine status and read data.
  typedef struct packed {
    logic              idle;
    logic              done;
    logic [ADDR_W-1:0] order;
    logic [ADDR_W-1:0] rank;
    logic [ADDR_W-1:0] prefix;
  } salcp_rsp_t;

endpackage

/* src/salcp_engine.sv */
module salcp_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  salcp_pkg::salcp_req_t req_i,
  output salcp_pkg::salcp_rsp_t rsp_o
);
  import salcp_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CLR   = 5'd1;
  localparam logic [4:0] S_CNT_A = 5'd2;
  localparam logic [4:0] S_CNT_B = 5'd3;
  localparam logic [4:0] S_CNT_C = 5'd4;
  localparam logic [4:0] S_PS_A  = 5'd5;
  localparam logic [4:0] S_PS_B  = 5'd6;
  localparam logic [4:0] S_SC2_A = 5'd7;
  localparam logic [4:0] S_SC2_B = 5'd8;
  localparam logic [4:0] S_SC2_C = 5'd9;
  localparam logic [4:0] S_SC2_D = 5'd10;
  localparam logic [4:0] S_CL_A  = 5'd11;
  localparam logic [4:0] S_CL_B  = 5'd12;
  localparam logic [4:0] S_CL_C  = 5'd13;
  localparam logic [4:0] S_CL_D  = 5'd14;
  localparam logic [4:0] S_CP_A  = 5'd15;
  localparam logic [4:0] S_CP_B  = 5'd16;
  localparam logic [4:0] S_LOOP  = 5'd17;
  localparam logic [4:0] S_FIN_A = 5'd18;
  localparam logic [4:0] S_FIN_B = 5'd19;
  localparam logic [4:0] S_KS_A  = 5'd20;
  localparam logic [4:0] S_KS_B  = 5'd21;
  localparam logic [4:0] S_KS_C  = 5'd22;
  localparam logic [4:0] S_KS_D  = 5'd23;
  localparam logic [4:0] S_KS_E  = 5'd24;
  localparam logic [4:0] S_KS_F  = 5'd25;
  localparam logic [4:0] S_DONE  = 5'd26;

  localparam logic [1:0] PH_INIT  = 2'd0;
  localparam logic [1:0] PH_SEC   = 2'd1;
  localparam logic [1:0] PH_FIRST = 2'd2;

  logic [4:0]        state_q, state_d;
  logic [1:0]        ph_q, ph_d;
  logic              scat_q, scat_d;
  logic [LEN_W-1:0]  n_q, n_d, h_q, h_d, cls_q, cls_d, ctr_q, ctr_d;
  logic [LEN_W-1:0]  sum_q, sum_d, k_q, k_d, key_q, key_d;
  logic [LEN_W-1:0]  pk1_q, pk1_d, pk2_q, pk2_d, k1_q, k1_d;
  logic [ADDR_W-1:0] p_q, p_d, j_q, j_d, r_q, r_d;
  logic [7:0]        c1_q, c1_d;

  logic [7:0]        text_mem [MAX_LEN];
  logic [ADDR_W-1:0] order_mem [MAX_LEN];
  logic [ADDR_W-1:0] rank_mem [MAX_LEN];
  logic [ADDR_W-1:0] next_mem [MAX_LEN];
  logic [ADDR_W-1:0] prefix_mem [MAX_LEN];
  logic [LEN_W-1:0]  cnt_mem [CNT_DEPTH];

  logic [7:0]        text_rd_q;
  logic [ADDR_W-1:0] order_rd_q, rank_rd_q, next_rd_q, prefix_rd_q;
  logic [LEN_W-1:0]  cnt_rd_q;

  logic              text_re, order_re, rank_re, next_re, prefix_re, cnt_re;
  logic [ADDR_W-1:0] text_ra, order_ra, rank_ra, next_ra, prefix_ra;
  logic [CNT_AW-1:0] cnt_ra;
  logic              text_we, order_we, rank_we, next_we, prefix_we, cnt_we;
  logic [ADDR_W-1:0] text_wa, order_wa, rank_wa, next_wa, prefix_wa;
  logic [CNT_AW-1:0] cnt_wa;
  logic [7:0]        text_wd;
  logic [ADDR_W-1:0] order_wd, rank_wd, next_wd, prefix_wd;
  logic [LEN_W-1:0]  cnt_wd;

  logic [LEN_W-1:0]  lim, ctr_inc, rank_inc, k1, k2, cn, base;
  logic [LEN_W:0]    ih, ph_sum, ik, jk;
  logic              ih_lt, ph_lt, head, fin, ctr_end, lim_end, ks_wr;

  assign ctr_inc  = ctr_q + LEN_W'(1);
  assign ctr_end  = (ctr_inc == n_q);
  assign lim_end  = (ctr_inc == lim);
  assign rank_inc = {1'b0, rank_rd_q} + LEN_W'(1);
  assign ih       = {1'b0, ctr_q} + {1'b0, h_q};
  assign ih_lt    = ih < {1'b0, n_q};
  assign ph_sum   = {2'b00, p_q} + {1'b0, h_q};
  assign ph_lt    = ph_sum < {1'b0, n_q};
  assign ik       = {1'b0, ctr_q} + {1'b0, k_q};
  assign jk       = {2'b00, j_q} + {1'b0, k_q};

  always_comb begin
    unique case (ph_q)
      PH_INIT: lim = LEN_W'(256);
      PH_SEC:  lim = cls_q + LEN_W'(1);
      default: lim = cls_q;
    endcase
  end

  always_comb begin
    state_d = state_q; ph_d = ph_q; scat_d = scat_q; n_d = n_q; h_d = h_q;
    cls_d = cls_q; ctr_d = ctr_q; sum_d = sum_q; k_d = k_q; key_d = key_q;
    pk1_d = pk1_q; pk2_d = pk2_q; k1_d = k1_q; p_d = p_q; j_d = j_q;
    r_d = r_q; c1_d = c1_q;

    text_re = 1'b0; text_ra = ctr_q[ADDR_W-1:0];
    order_re = (state_q == S_IDLE) && req_i.rd_en; order_ra = req_i.rd_idx;
    rank_re = order_re; rank_ra = req_i.rd_idx;
    prefix_re = order_re; prefix_ra = req_i.rd_idx;
    next_re = 1'b0; next_ra = ctr_q[ADDR_W-1:0];
    cnt_re = 1'b0; cnt_ra = ctr_q;

    text_we = (state_q == S_IDLE) && req_i.wr_en;
    text_wa = req_i.wr_addr; text_wd = req_i.wr_data;
    order_we = 1'b0; order_wa = cnt_rd_q[ADDR_W-1:0]; order_wd = ctr_q[ADDR_W-1:0];
    rank_we = 1'b0; rank_wa = ctr_q[ADDR_W-1:0]; rank_wd = next_rd_q;
    next_we = 1'b0; next_wa = cnt_rd_q[ADDR_W-1:0]; next_wd = ctr_q[ADDR_W-1:0];
    prefix_we = 1'b0; prefix_wa = r_q; prefix_wd = k_q[ADDR_W-1:0];
    cnt_we = 1'b0; cnt_wa = ctr_q; cnt_wd = '0;

    k1 = k1_q; k2 = '0; fin = 1'b0; ks_wr = 1'b0;
    base = (ctr_q == '0) ? '0 : cls_q;
    head = 1'b0; cn = cls_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          n_d = req_i.n; ph_d = PH_INIT; h_d = LEN_W'(1);
          ctr_d = '0; state_d = S_CLR;
        end
      end
      S_CLR: begin
        cnt_we = 1'b1;
        ctr_d  = ctr_inc;
        if (lim_end) begin
          ctr_d = '0; scat_d = 1'b0; state_d = S_CNT_A;
        end
      end
      S_CNT_A: begin
        text_re = 1'b1;
        rank_re = 1'b1;
        rank_ra = (ph_q == PH_SEC) ? ih[ADDR_W-1:0] : ctr_q[ADDR_W-1:0];
        state_d = S_CNT_B;
      end
      S_CNT_B: begin
        unique case (ph_q)
          PH_INIT: key_d = {{(LEN_W-8){1'b0}}, text_rd_q};
          PH_SEC:  key_d = ih_lt ? rank_inc : '0;
          default: key_d = {1'b0, rank_rd_q};
        endcase
        cnt_re  = 1'b1;
        cnt_ra  = key_d;
        state_d = S_CNT_C;
      end
      S_CNT_C: begin
        cnt_we = 1'b1; cnt_wa = key_q; cnt_wd = cnt_rd_q + LEN_W'(1);
        if (scat_q) begin
          order_we = (ph_q == PH_INIT);
          next_we  = (ph_q == PH_SEC);
        end
        ctr_d   = ctr_inc;
        state_d = S_CNT_A;
        if (ctr_end) begin
          ctr_d = '0;
          if (!scat_q) begin
            sum_d = '0; state_d = S_PS_A;
          end else if (ph_q == PH_INIT) begin
            state_d = S_CL_A;
          end else begin
            ph_d = PH_FIRST; state_d = S_CLR;
          end
        end
      end
      S_PS_A: begin
        cnt_re = 1'b1;
        state_d = S_PS_B;
      end
      S_PS_B: begin
        cnt_we = 1'b1; cnt_wd = sum_q;
        sum_d = sum_q + cnt_rd_q;
        ctr_d = ctr_inc;
        state_d = S_PS_A;
        if (lim_end) begin
          ctr_d = '0;
          if (ph_q == PH_FIRST) begin
            state_d = S_SC2_A;
          end else begin
            scat_d = 1'b1; state_d = S_CNT_A;
          end
        end
      end
      S_SC2_A: begin
        next_re = 1'b1;
        state_d = S_SC2_B;
      end
      S_SC2_B: begin
        p_d = next_rd_q; rank_re = 1'b1; rank_ra = next_rd_q;
        state_d = S_SC2_C;
      end
      S_SC2_C: begin
        key_d = {1'b0, rank_rd_q};
        cnt_re = 1'b1; cnt_ra = {1'b0, rank_rd_q};
        state_d = S_SC2_D;
      end
      S_SC2_D: begin
        order_we = 1'b1; order_wd = p_q;
        cnt_we = 1'b1; cnt_wa = key_q; cnt_wd = cnt_rd_q + LEN_W'(1);
        ctr_d = ctr_inc;
        state_d = S_SC2_A;
        if (ctr_end) begin
          ctr_d = '0; state_d = S_CL_A;
        end
      end
      S_CL_A: begin
        order_re = 1'b1; order_ra = ctr_q[ADDR_W-1:0];
        state_d = S_CL_B;
      end
      S_CL_B: begin
        p_d = order_rd_q;
        text_re = 1'b1; text_ra = order_rd_q;
        rank_re = 1'b1; rank_ra = order_rd_q;
        state_d = S_CL_C;
      end
      S_CL_C: begin
        if (ph_q == PH_INIT) begin
          k1  = {{(LEN_W-8){1'b0}}, text_rd_q};
          fin = 1'b1;
        end else begin
          k1_d = {1'b0, rank_rd_q};
          rank_re = 1'b1; rank_ra = ph_sum[ADDR_W-1:0];
          state_d = S_CL_D;
        end
      end
      S_CL_D: begin
        k2  = ph_lt ? rank_inc : '0;
        fin = 1'b1;
      end
      S_CP_A: begin
        next_re = 1'b1;
        state_d = S_CP_B;
      end
      S_CP_B: begin
        rank_we = 1'b1;
        ctr_d = ctr_inc;
        state_d = S_CP_A;
        if (ctr_end) begin
          ctr_d = '0; h_d = {h_q[LEN_W-2:0], 1'b0}; state_d = S_LOOP;
        end
      end
      S_LOOP: begin
        ctr_d = '0;
        if (cls_q < n_q && h_q < n_q) begin
          ph_d = PH_SEC; state_d = S_CLR;
        end else begin
          state_d = S_FIN_A;
        end
      end
      S_FIN_A: begin
        order_re = 1'b1; order_ra = ctr_q[ADDR_W-1:0];
        state_d = S_FIN_B;
      end
      S_FIN_B: begin
        rank_we = 1'b1; rank_wa = order_rd_q; rank_wd = ctr_q[ADDR_W-1:0];
        ctr_d = ctr_inc;
        state_d = S_FIN_A;
        if (ctr_end) begin
          ctr_d = '0; k_d = '0; state_d = S_KS_A;
        end
      end
      S_KS_A: begin
        rank_re = 1'b1; rank_ra = ctr_q[ADDR_W-1:0];
        state_d = S_KS_B;
      end
      S_KS_B: begin
        r_d = rank_rd_q;
        if (rank_inc >= n_q) begin
          // The suffix at the last rank has no neighbor; the run restarts.
          k_d = '0;
          ctr_d = ctr_inc;
          state_d = ctr_end ? S_DONE : S_KS_A;
        end else begin
          order_re = 1'b1; order_ra = rank_inc[ADDR_W-1:0];
          state_d = S_KS_C;
        end
      end
      S_KS_C: begin
        j_d = order_rd_q;
        state_d = S_KS_D;
      end
      S_KS_D: begin
        if (ik < {1'b0, n_q} && jk < {1'b0, n_q}) begin
          text_re = 1'b1; text_ra = ik[ADDR_W-1:0];
          state_d = S_KS_E;
        end else begin
          ks_wr = 1'b1;
        end
      end
      S_KS_E: begin
        c1_d = text_rd_q;
        text_re = 1'b1; text_ra = jk[ADDR_W-1:0];
        state_d = S_KS_F;
      end
      S_KS_F: begin
        if (text_rd_q == c1_q) begin
          k_d = k_q + LEN_W'(1);
          state_d = S_KS_D;
        end else begin
          ks_wr = 1'b1;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase

    // Bucket head detection shared by the initial and the doubling class passes.
    if (fin) begin
      head = (ctr_q == '0) || (k1 != pk1_q) || (k2 != pk2_q);
      cn = base + {{(LEN_W-1){1'b0}}, head};
      cls_d = cn; pk1_d = k1; pk2_d = k2;
      if (ph_q == PH_INIT) begin
        rank_we = 1'b1; rank_wa = p_q; rank_wd = cn[ADDR_W-1:0] - ADDR_W'(1);
      end else begin
        next_we = 1'b1; next_wa = p_q; next_wd = cn[ADDR_W-1:0] - ADDR_W'(1);
      end
      ctr_d = ctr_inc;
      state_d = S_CL_A;
      if (ctr_end) begin
        ctr_d = '0;
        state_d = (ph_q == PH_INIT) ? S_LOOP : S_CP_A;
      end
    end

    // Kasai keeps k minus one for the next text position.
    if (ks_wr) begin
      prefix_we = 1'b1;
      k_d = (k_q != '0) ? k_q - LEN_W'(1) : '0;
      ctr_d = ctr_inc;
      state_d = ctr_end ? S_DONE : S_KS_A;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q <= PH_INIT; scat_q <= 1'b0; n_q <= '0; h_q <= '0; cls_q <= '0;
      ctr_q <= '0; sum_q <= '0; k_q <= '0; key_q <= '0; pk1_q <= '0;
      pk2_q <= '0; k1_q <= '0; p_q <= '0; j_q <= '0; r_q <= '0; c1_q <= '0;
    end else begin
      state_q <= state_d;
      ph_q <= ph_d; scat_q <= scat_d; n_q <= n_d; h_q <= h_d; cls_q <= cls_d;
      ctr_q <= ctr_d; sum_q <= sum_d; k_q <= k_d; key_q <= key_d; pk1_q <= pk1_d;
      pk2_q <= pk2_d; k1_q <= k1_d; p_q <= p_d; j_q <= j_d; r_q <= r_d; c1_q <= c1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_we) text_mem[text_wa] <= text_wd;
    if (text_re) text_rd_q <= text_mem[text_ra];
  end

  always_ff @(posedge clk_i) begin
    if (order_we) order_mem[order_wa] <= order_wd;
    if (order_re) order_rd_q <= order_mem[order_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rank_we) rank_mem[rank_wa] <= rank_wd;
    if (rank_re) rank_rd_q <= rank_mem[rank_ra];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (next_re) next_rd_q <= next_mem[next_ra];
  end

  always_ff @(posedge clk_i) begin
    if (prefix_we) prefix_mem[prefix_wa] <= prefix_wd;
    if (prefix_re) prefix_rd_q <= prefix_mem[prefix_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (cnt_re) cnt_rd_q <= cnt_mem[cnt_ra];
  end

  assign rsp_o.idle   = (state_q == S_IDLE);
  assign rsp_o.done   = (state_q == S_DONE);
  assign rsp_o.order  = order_rd_q;
  assign rsp_o.rank   = rank_rd_q;
  assign rsp_o.prefix = prefix_rd_q;

endmodule

/* src/suffix_array_lcp_builder_unit.sv */
// Suffix array and LCP builder.
// The slave stream takes one request per cycle. tuser selects the operation:
// 0 loads the byte in tdata[7:0] at the end of the text, 1 reads the results
// for the index in tdata[17:8]. A load with tlast high starts the build.
// A load after a finished build starts a new text; bytes past 1024 are dropped.
// Each read gives one result on the master stream in the cycle after it is
// taken: suffix start at that rank, rank of that position, common prefix with
// the next rank, its valid flag and a status (ok, not built, out of range).
// Loads and reads are taken back to back, one per cycle, while the result
// register is empty or being drained. If the receiver stalls, the pending
// result holds and tready drops until it is taken.
// The build runs on a sequencer with one read port per memory and stalls the
// slave stream. Each counting pass clears the buckets, counts the keys, forms
// prefix sums and scatters; the first sort keys on the bytes, each doubling
// round (up to log2(n) rounds) on rank pairs, then a final rank pass and the
// Kasai LCP pass follow, with at most 2n matched characters overall.
// Reset empties the text and marks the results as not built.
module suffix_array_lcp_builder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // char_value[7:0], index[17:8], zero pad
  input  logic        s_axis_tlast,
  input  logic [0:0]  s_axis_tuser,  // operation[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // suffix_start[9:0], rank_of_position[19:10], common_prefix[29:20],
  // prefix_valid[30], status[32:31], zero pad
  output logic [39:0] m_axis_tdata
);
  import salcp_pkg::*;

  salcp_req_t        req;
  salcp_rsp_t        rsp;
  logic              acc, ld, rd, wr_ok;
  logic [LEN_W-1:0]  len_q, len_d, base;
  logic              built_q, built_d, ov_q, ov_d;
  logic [1:0]        status_q, status_d;
  logic              pv_q, pv_d, ok;
  logic [ADDR_W-1:0] idx;

  salcp_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign s_axis_tready = rsp.idle && (!ov_q || m_axis_tready);
  assign acc   = s_axis_tvalid && s_axis_tready;
  assign ld    = acc && !s_axis_tuser[0];
  assign rd    = acc && s_axis_tuser[0];
  assign idx   = s_axis_tdata[17:8];
  assign base  = built_q ? '0 : len_q;
  assign wr_ok = base < LEN_W'(MAX_LEN);

  always_comb begin
    req.rd_en   = rd;
    req.rd_idx  = idx;
    req.wr_en   = ld && wr_ok;
    req.wr_addr = base[ADDR_W-1:0];
    req.wr_data = s_axis_tdata[7:0];
    req.start   = ld && s_axis_tlast;
    req.n       = wr_ok ? base + LEN_W'(1) : base;
  end

  always_comb begin
    len_d = len_q; built_d = built_q; ov_d = ov_q;
    status_d = status_q; pv_d = pv_q;
    if (ld) begin
      len_d = req.n; built_d = 1'b0;
    end
    if (rsp.done) built_d = 1'b1;
    if (m_axis_tvalid && m_axis_tready) ov_d = 1'b0;
    if (rd) begin
      ov_d = 1'b1;
      pv_d = 1'b0;
      if (!built_q) begin
        status_d = ST_NOT_BUILT;
      end else if ({1'b0, idx} >= len_q) begin
        status_d = ST_RANGE;
      end else begin
        status_d = ST_OK;
        pv_d = ({1'b0, idx} + LEN_W'(1)) < len_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0; built_q <= 1'b0; ov_q <= 1'b0;
      status_q <= ST_OK; pv_q <= 1'b0;
    end else begin
      len_q <= len_d; built_q <= built_d; ov_q <= ov_d;
      status_q <= status_d; pv_q <= pv_d;
    end
  end

  // The engine read registers hold the data while the request waits here.
  assign ok = (status_q == ST_OK);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = {7'd0, status_q, pv_q,
                         pv_q ? rsp.prefix : {ADDR_W{1'b0}},
                         ok ? rsp.rank : {ADDR_W{1'b0}},
                         ok ? rsp.order : {ADDR_W{1'b0}}};

`ifndef SYNTHESIS
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp.idle |-> !s_axis_tready) else $error("request taken during build");
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd |=> m_axis_tvalid) else $error("read gave no result");
  a_build_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld && s_axis_tlast) |=> !rsp.idle) else $error("build did not start");
  a_built_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(built_q) |-> rsp.idle) else $error("built set while engine busy");
`endif

endmodule
